// ===== sv/mm_pkg.sv =====
// Shared types, constants and helpers for the matrix multiply block.
// No dependencies; compiled first.
package mm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int ELEM_BITS = 16;

  localparam int IDX_W   = 3;
  localparam int DIM_W   = 4;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 40;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int MUL_W   = 2 * ELEM_BITS;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Item modes
  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_CALC = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ROWS_A     = 2'd0;
  localparam logic [1:0] REG_SHARED_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B     = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [MUL_W-1:0]     mul_t;
  typedef logic signed [PROD_W-1:0]    acc_t;
  typedef logic [ADDR_W-1:0]           addr_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic  wr_a;
    logic  wr_b;
    addr_t wr_addr;
    elem_t wr_data;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    logic  first;
    logic  last;
  } mm_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic done;
    acc_t acc;
  } mm_stat_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = d;
    end
    return r;
  endfunction

  function automatic addr_t elem_addr(input logic [IDX_W-1:0] r,
                                      input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
  endfunction

endpackage

// ===== sv/mm_if.sv =====
// Request and result channel interfaces for the matrix multiply block.
// Depends on mm_pkg.
interface mm_in_if;
  import mm_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

interface mm_out_if;
  import mm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [PROD_W-1:0] product;
  logic                     last;

  modport source (output valid, out_row, out_col, product, last, input ready);
  modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

// ===== sv/mm_datapath.sv =====
// Element memories for A and B plus the shared multiply-accumulate pipeline.
// Depends on mm_pkg.
module mm_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm_pkg::mm_ctrl_t ctrl_i,
  output mm_pkg::mm_stat_t stat_o
);
  import mm_pkg::*;

  elem_t store_a [0:DEPTH-1];
  elem_t store_b [0:DEPTH-1];

  elem_t a_rd_q, b_rd_q;
  mul_t  mul_q;
  acc_t  acc_q;
  logic  s1_valid_q, s1_first_q, s1_last_q;
  logic  s2_valid_q, s2_first_q, s2_last_q;
  logic  done_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_a) begin
      store_a[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
    if (ctrl_i.wr_b) begin
      store_b[ctrl_i.wr_addr] <= ctrl_i.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      a_rd_q <= store_a[ctrl_i.rd_addr_a];
      b_rd_q <= store_b[ctrl_i.rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      mul_q <= a_rd_q * b_rd_q;
    end
    if (s2_valid_q) begin
      acc_q <= s2_first_q ? PROD_W'(mul_q) : acc_q + PROD_W'(mul_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= ctrl_i.rd_en;
      s1_first_q <= ctrl_i.first;
      s1_last_q  <= ctrl_i.last;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_valid_q & s2_last_q;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.acc  = acc_q;

endmodule

// ===== sv/matrix_multiply.sv =====
// Matrix multiply top level: APB register file, item sequencer, result register.
// Depends on mm_pkg, mm_in_if, mm_out_if and mm_datapath.
//
// Computes C = A x B with A of rows_a x shared_dim and B of shared_dim x cols_b
// (each 1..8; a register of 0 acts as 1, above 8 acts as 8). Mode 0 and mode 1
// requests write one signed Q8.8 element of A or B. A mode 2 request streams
// every element of C in row-major order as signed Q24.16 sums, with last set
// on the final one. A single multiply-accumulate unit fed by registered reads
// of the A and B element memories does all the work, one result element at a
// time, and a stall on the result side holds the compute. Requests are refused
// while a compute is running; the next request is taken as soon as the final
// result sits in the output register. Elements read by a compute must have
// been written since reset. Registers live at byte addresses 0, 4 and 8 and
// are to be written only while idle by the user; the block does not enforce it.
module matrix_multiply (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mm_pkg::APB_AW-1:0] paddr,
  input  logic [mm_pkg::APB_DW-1:0] pwdata,
  output logic [mm_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  mm_in_if.sink                     in_req,
  mm_out_if.source                  out_res
);
  import mm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;  // issuing reads for one element
  localparam logic [1:0] ST_DRAIN = 2'd2;  // waiting for the MAC pipeline
  localparam logic [1:0] ST_EMIT  = 2'd3;  // waiting for a free output slot

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] rows_a_q, shared_dim_q, cols_b_q;
  logic [1:0]       cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= DIM_RESET;
      shared_dim_q <= DIM_RESET;
      cols_b_q     <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROWS_A:     rows_a_q     <= pwdata[DIM_W-1:0];
        REG_SHARED_DIM: shared_dim_q <= pwdata[DIM_W-1:0];
        REG_COLS_B:     cols_b_q     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS_A:     prdata = APB_DW'(rows_a_q);
      REG_SHARED_DIM: prdata = APB_DW'(shared_dim_q);
      REG_COLS_B:     prdata = APB_DW'(cols_b_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] m_q, m_d, k_q, k_d, n_q, n_d;   // clamped dims of this run
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, l_q, l_d;

  logic     in_fire;
  logic     wr_ok;
  logic     l_end, j_end, i_end;
  logic     slot_free;
  logic     load_out;
  mm_ctrl_t ctrl;
  mm_stat_t stat;

  assign in_req.ready = (state_q == ST_IDLE);
  assign in_fire      = in_req.valid & in_req.ready;
  // Writes with an index at or above the store size are dropped
  assign wr_ok = ({1'b0, in_req.row} < DIM_W'(MAX_DIM)) &&
                 ({1'b0, in_req.col} < DIM_W'(MAX_DIM));

  assign l_end = (DIM_W'(l_q) + DIM_W'(1)) == k_q;
  assign j_end = (DIM_W'(j_q) + DIM_W'(1)) == n_q;
  assign i_end = (DIM_W'(i_q) + DIM_W'(1)) == m_q;

  assign slot_free = ~out_res.valid | out_res.ready;
  assign load_out  = (state_q == ST_EMIT) & slot_free;

  always_comb begin
    ctrl.wr_a      = in_fire & (in_req.mode == MODE_WR_A) & wr_ok;
    ctrl.wr_b      = in_fire & (in_req.mode == MODE_WR_B) & wr_ok;
    ctrl.wr_addr   = elem_addr(in_req.row, in_req.col);
    ctrl.wr_data   = ELEM_BITS'(in_req.value);
    ctrl.rd_en     = (state_q == ST_RUN);
    ctrl.rd_addr_a = elem_addr(i_q, l_q);
    ctrl.rd_addr_b = elem_addr(l_q, j_q);
    ctrl.first     = (state_q == ST_RUN) & (l_q == '0);
    ctrl.last      = (state_q == ST_RUN) & l_end;
  end

  always_comb begin
    state_d = state_q;
    m_d = m_q;
    k_d = k_q;
    n_d = n_q;
    i_d = i_q;
    j_d = j_q;
    l_d = l_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_req.mode == MODE_CALC) begin
          m_d = clamp_dim(rows_a_q);
          k_d = clamp_dim(shared_dim_q);
          n_d = clamp_dim(cols_b_q);
          i_d = '0;
          j_d = '0;
          l_d = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (l_end) begin
          l_d = '0;
          state_d = ST_DRAIN;
        end else begin
          l_d = l_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          if (i_end && j_end) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
            if (j_end) begin
              j_d = '0;
              i_d = i_q + IDX_W'(1);
            end else begin
              j_d = j_q + IDX_W'(1);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      m_q <= DIM_RESET;
      k_q <= DIM_RESET;
      n_q <= DIM_RESET;
      i_q <= '0;
      j_q <= '0;
      l_q <= '0;
    end else begin
      state_q <= state_d;
      m_q <= m_d;
      k_q <= k_d;
      n_q <= n_d;
      i_q <= i_d;
      j_q <= j_d;
      l_q <= l_d;
    end
  end

  mm_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  // ---------------------------------------------------------------------------
  // Result register: parts the result side from the sequencer
  // ---------------------------------------------------------------------------
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [PROD_W-1:0] product_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q <= i_q;
      out_col_q <= j_q;
      product_q <= stat.acc;
      last_q    <= i_end & j_end;
    end
  end

  assign out_res.valid   = out_valid_q;
  assign out_res.out_row = out_row_q;
  assign out_res.out_col = out_col_q;
  assign out_res.product = product_q;
  assign out_res.last    = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.done |-> (state_q == ST_DRAIN))
    else $error("MAC done outside drain");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |->
      (DIM_W'(i_q) < m_q) && (DIM_W'(j_q) < n_q) && (DIM_W'(l_q) < k_q))
    else $error("sequencer index beyond dimension");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && i_end && j_end) |=> (state_q == ST_IDLE) && out_res.last)
    else $error("final element did not end the run");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(ctrl.wr_a || ctrl.wr_b))
    else $error("store write during compute");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the matrix multiply block (C = A x B).
// Depends on mm_pkg, mm_in_if, mm_out_if and matrix_multiply; keeps a shadow of
// both element stores and the dimension registers to predict every C element.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mm_pkg::*;

  // Codes the package leaves out: the unused mode and the unused register slot.
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS  = 40;
  localparam int SETTLE_CYCLES = 16;

  // One predicted element of C
  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] dot;
    logic                     last;
  } c_elem_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mm_in_if  in_req ();
  mm_out_if out_res ();

  matrix_multiply DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_req  (in_req.sink),
    .out_res (out_res.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: element stores, which entries hold data, registers.
  elem_t            a_mem [DEPTH];
  elem_t            b_mem [DEPTH];
  bit               a_loaded [DEPTH];
  bit               b_loaded [DEPTH];
  logic [DIM_W-1:0] rows_cfg;
  logic [DIM_W-1:0] inner_cfg;
  logic [DIM_W-1:0] cols_cfg;

  c_elem_t c_pending[$];   // C elements still owed by the block, oldest first
  int      mismatches = 0;
  int      items_sent = 0; // accepted requests of modes 0..2
  bit      no_idle    = 1'b0;

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  // Register value to dimension actually used: 0 acts as 1, above 8 as 8.
  function automatic int eff_dim(input logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  // Mostly random operands over the full range, now and then an extreme value.
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 11))
      0:       return elem_t'(16'sh8000);
      1:       return elem_t'(16'sh7FFF);
      2:       return elem_t'(-1);
      3:       return elem_t'(0);
      default: return elem_t'($urandom());
    endcase
  endfunction

  // Dimension register value: small sizes dominate, 0 and 9..15 show up too.
  function automatic logic [DIM_W-1:0] pick_dim();
    int e;
    e = ($urandom_range(0, 4) == 0) ? $urandom_range(4, MAX_DIM) : $urandom_range(1, 3);
    if (e == 1 && $urandom_range(0, 2) == 0) return '0;
    if (e == MAX_DIM && $urandom_range(0, 1) == 1) return DIM_W'($urandom_range(9, 15));
    return DIM_W'(e);
  endfunction

  // Apply one accepted request to the shadow; a compute queues all of C.
  task automatic shadow_matmul(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col, input elem_t value);
    int                m;
    int                k;
    int                n;
    logic signed [63:0] acc;
    logic signed [MUL_W-1:0] term;
    c_elem_t           elem;
    case (mode)
      MODE_WR_A: begin
        a_mem[int'(row) * MAX_DIM + int'(col)]    = value;
        a_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      end
      MODE_WR_B: begin
        b_mem[int'(row) * MAX_DIM + int'(col)]    = value;
        b_loaded[int'(row) * MAX_DIM + int'(col)] = 1'b1;
      end
      MODE_CALC: begin
        m = eff_dim(rows_cfg);
        k = eff_dim(inner_cfg);
        n = eff_dim(cols_cfg);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int l = 0; l < k; l++) begin
              term = a_mem[i * MAX_DIM + l] * b_mem[l * MAX_DIM + j];
              acc += term;
            end
            elem.row  = IDX_W'(i);
            elem.col  = IDX_W'(j);
            elem.dot  = acc[PROD_W-1:0];
            elem.last = (i == m - 1) && (j == n - 1);
            c_pending.push_back(elem);
          end
        end
      end
      default: ;   // unused mode: dropped by the block
    endcase
  endtask

  // Present one request; valid stays high afterwards unless the next call idles.
  task automatic send_req(input logic [1:0] mode, input logic [IDX_W-1:0] row,
                          input logic [IDX_W-1:0] col, input elem_t value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.mode  <= mode;
    in_req.row   <= row;
    in_req.col   <= col;
    in_req.value <= value;
    do @(posedge clk_i); while (in_req.ready !== 1'b1);
    shadow_matmul(mode, row, col, value);
    if (mode != MODE_NONE) items_sent++;
  endtask

  // Compute request; its row, col and value fields are don't-care, so randomize them.
  task automatic send_calc();
    send_req(MODE_CALC, IDX_W'($urandom()), IDX_W'($urandom()), elem_t'($urandom()));
  endtask

  // Drop valid, let every owed element come back, then let the block settle.
  task automatic drain_results();
    in_req.valid <= 1'b0;
    while (c_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB transfers run back to back; a group ends with apb_idle in the same step.
  task automatic apb_write(input logic [1:0] idx, input logic [DIM_W-1:0] dim);
    logic [APB_DW-1:0] data;
    data = $urandom();
    data[DIM_W-1:0] = dim;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_ROWS_A:     rows_cfg  = dim;
      REG_SHARED_DIM: inner_cfg = dim;
      REG_COLS_B:     cols_cfg  = dim;
      default: ;
    endcase
  endtask

  task automatic apb_read(input logic [1:0] idx, output logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    data = prdata;
  endtask

  task automatic apb_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read back all three dimension registers and close the APB group.
  task automatic check_dims();
    logic [1:0]       regs  [3] = '{REG_ROWS_A, REG_SHARED_DIM, REG_COLS_B};
    string            names [3] = '{"rows_a", "shared_dim", "cols_b"};
    logic [DIM_W-1:0] want  [3];
    logic [APB_DW-1:0] rd;
    want = '{rows_cfg, inner_cfg, cols_cfg};
    for (int r = 0; r < 3; r++) begin
      apb_read(regs[r], rd);
      if (rd[DIM_W-1:0] !== want[r]) begin
        $error("%s readback: expected %0d, got %0d", names[r], want[r], rd[DIM_W-1:0]);
        mismatches++;
      end
    end
    apb_idle();
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] rv, input logic [DIM_W-1:0] sv,
                          input logic [DIM_W-1:0] cv);
    drain_results();
    apb_write(REG_ROWS_A, rv);
    apb_write(REG_SHARED_DIM, sv);
    apb_write(REG_COLS_B, cv);
    check_dims();
  endtask

  // Ignored mode, or a write anywhere in the 8x8 stores (outside dims still lands).
  task automatic send_noise();
    if ($urandom_range(0, 2) == 0)
      send_req(MODE_NONE, IDX_W'($urandom()), IDX_W'($urandom()), elem_t'($urandom()));
    else
      send_req($urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A, IDX_W'($urandom()),
               IDX_W'($urandom()), rand_elem());
  endtask

  // Load every A and B entry the next compute reads and that has no data yet,
  // plus some rewrites, in shuffled order with noise mixed in.
  task automatic load_operands(input int m, input int k, input int n);
    int slots[$];
    int pick;
    int tmp;
    for (int i = 0; i < m; i++)
      for (int l = 0; l < k; l++)
        if (!a_loaded[i * MAX_DIM + l] || $urandom_range(0, 3) == 0)
          slots.push_back(i * MAX_DIM + l);
    for (int l = 0; l < k; l++)
      for (int j = 0; j < n; j++)
        if (!b_loaded[l * MAX_DIM + j] || $urandom_range(0, 3) == 0)
          slots.push_back(DEPTH + l * MAX_DIM + j);
    for (int s = slots.size() - 1; s > 0; s--) begin
      pick        = $urandom_range(0, s);
      tmp         = slots[s];
      slots[s]    = slots[pick];
      slots[pick] = tmp;
    end
    foreach (slots[s]) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      send_req(slots[s] >= DEPTH ? MODE_WR_B : MODE_WR_A,
               IDX_W'((slots[s] % DEPTH) / MAX_DIM), IDX_W'(slots[s] % MAX_DIM),
               rand_elem());
    end
  endtask

  // One configuration, full operand load, one or three computes.
  task automatic run_phase(input logic [DIM_W-1:0] rv, input logic [DIM_W-1:0] sv,
                           input logic [DIM_W-1:0] cv);
    int m;
    int k;
    int n;
    m = eff_dim(rv);
    k = eff_dim(sv);
    n = eff_dim(cv);
    set_dims(rv, sv, cv);
    no_idle = ($urandom_range(0, 4) == 0);
    load_operands(m, k, n);
    send_calc();
    if ($urandom_range(0, 1) == 1) begin
      // Touch one operand and compute twice more, right behind the first one.
      send_req(MODE_WR_A, IDX_W'($urandom_range(0, m - 1)), IDX_W'($urandom_range(0, k - 1)),
               rand_elem());
      send_calc();
      send_calc();
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_dims();
    check_dims();
  endtask

  // Registers of 0 act as 1: a 1x1x1 product with extreme operands,
  // and unused-mode requests must leave the stores alone.
  task automatic test_min_dims();
    set_dims('0, '0, '0);
    send_req(MODE_WR_A, 3'd0, 3'd0, elem_t'(16'sh8000));
    send_req(MODE_WR_B, 3'd0, 3'd0, elem_t'(16'sh8000));
    send_calc();
    send_req(MODE_WR_A, 3'd0, 3'd0, elem_t'(16'sh7FFF));
    send_calc();
    send_req(MODE_NONE, 3'd0, 3'd0, elem_t'(16'sh1234));
    send_req(MODE_NONE, 3'd7, 3'd7, elem_t'(-1));
    send_calc();
  endtask

  // Writes outside the current dims are still stored and used once dims grow.
  task automatic test_outside_dims();
    send_req(MODE_WR_A, 3'd0, 3'd1, elem_t'(-1));
    send_req(MODE_WR_B, 3'd1, 3'd0, elem_t'(16'sh7FFF));
    set_dims(4'd1, 4'd2, 4'd1);
    send_calc();
  endtask

  // The fourth register slot holds nothing; the real ones must not move.
  task automatic test_unused_register();
    drain_results();
    apb_write(REG_UNUSED, '1);
    check_dims();
  endtask

  task automatic test_value_extremes();
    set_dims(4'd2, 4'd2, 4'd2);
    send_req(MODE_WR_A, 3'd1, 3'd0, elem_t'(16'sh8000));
    send_req(MODE_WR_A, 3'd1, 3'd1, elem_t'(16'sh8000));
    send_req(MODE_WR_B, 3'd0, 3'd1, elem_t'(16'sh8000));
    send_req(MODE_WR_B, 3'd1, 3'd1, elem_t'(16'sh8000));
    send_calc();
    send_calc();
  endtask

  task automatic test_random_phases();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) run_phase(pick_dim(), pick_dim(), pick_dim());
  endtask

  // Registers at 15 act as 8; shapes chosen so the loads stay short.
  task automatic test_max_dims();
    run_phase(4'd15, 4'd1, 4'd15);
    run_phase(4'd1, 4'd15, 4'd1);
    run_phase(4'd8, 4'd2, 4'd8);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : c_checker
    int      hold;
    c_elem_t want;
    out_res.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_res.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_res.ready <= 1'b1;
      do @(posedge clk_i); while (out_res.valid !== 1'b1);
      if (c_pending.size() == 0) begin
        $error("result with nothing pending: row %0d col %0d product %0d",
               out_res.out_row, out_res.out_col, out_res.product);
        mismatches++;
      end else begin
        want = c_pending.pop_front();
        if (out_res.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_res.out_row);
          mismatches++;
        end
        if (out_res.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_res.out_col);
          mismatches++;
        end
        if (out_res.product !== want.dot) begin
          $error("product: expected %0d, got %0d", $signed(want.dot),
                 $signed(out_res.product));
          mismatches++;
        end
        if (out_res.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_res.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_req.valid = 1'b0;
    in_req.mode  = MODE_WR_A;
    in_req.row   = '0;
    in_req.col   = '0;
    in_req.value = '0;
    rows_cfg     = DIM_RESET;
    inner_cfg    = DIM_RESET;
    cols_cfg     = DIM_RESET;
    foreach (a_mem[i]) begin
      a_mem[i]    = '0;
      b_mem[i]    = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_dims();
    test_min_dims();
    test_outside_dims();
    test_unused_register();
    test_value_extremes();
    test_random_phases();
    test_max_dims();

    drain_results();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
